### hdl/sdrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdrm_pkg
// Types, constants and the control store of the signed divider sequencer.
// ----------------------------------------------------------------------------
package sdrm_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = 5;
    localparam int unsigned KIND_W = 3;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [KIND_W-1:0]        t_kind;
    typedef logic [CNT_W-1:0]         t_cnt;

    localparam t_word WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam t_word WORD_ONE = t_word'(1);
    localparam t_cnt  CNT_LAST = t_cnt'(DATA_W - 1);

    // request kinds
    localparam t_kind KIND_NUM_EMIT  = 3'd0;
    localparam t_kind KIND_DEN_EMIT  = 3'd1;
    localparam t_kind KIND_BOTH_EMIT = 3'd2;
    localparam t_kind KIND_EMIT      = 3'd3;
    localparam t_kind KIND_NUM_SET   = 3'd4;
    localparam t_kind KIND_DEN_SET   = 3'd5;

    // microprogram step addresses
    typedef logic [2:0] t_step;
    localparam t_step STEP_IDLE = 3'd0;
    localparam t_step STEP_LOAD = 3'd1;
    localparam t_step STEP_ITER = 3'd2;
    localparam t_step STEP_SIGN = 3'd3;
    localparam t_step STEP_MOD  = 3'd4;
    localparam t_step STEP_OUT  = 3'd5;

    typedef enum logic [2:0] {
        OP_NOP  = 3'd0,
        OP_LOAD = 3'd1,
        OP_STEP = 3'd2,
        OP_SIGN = 3'd3,
        OP_MOD  = 3'd4,
        OP_OUT  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        COND_START    = 2'd0,
        COND_SPECIAL  = 2'd1,
        COND_CNT_MORE = 2'd2,
        COND_OUT_BUSY = 2'd3
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step jt;   // next step when cond holds
        t_step jf;   // next step otherwise
    } t_ctrl;

    function automatic t_ctrl sdrm_rom(input t_step s);
        t_ctrl w;
        unique case (s)
            STEP_IDLE: w = '{OP_NOP,  COND_START,    STEP_LOAD, STEP_IDLE};
            STEP_LOAD: w = '{OP_LOAD, COND_SPECIAL,  STEP_OUT,  STEP_ITER};
            STEP_ITER: w = '{OP_STEP, COND_CNT_MORE, STEP_ITER, STEP_SIGN};
            STEP_SIGN: w = '{OP_SIGN, COND_START,    STEP_MOD,  STEP_MOD};
            STEP_MOD:  w = '{OP_MOD,  COND_START,    STEP_OUT,  STEP_OUT};
            STEP_OUT:  w = '{OP_OUT,  COND_OUT_BUSY, STEP_OUT,  STEP_IDLE};
            default:   w = '{OP_NOP,  COND_START,    STEP_IDLE, STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

### hdl/sdrm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdrm_req_if / sdrm_rsp_if
// Valid/ready channels for requests and division results.
// ----------------------------------------------------------------------------
interface sdrm_req_if
    import sdrm_pkg::*;
;
    logic  valid;
    logic  ready;
    t_kind req_type;
    t_word first_value;
    t_word second_value;

    modport source (output valid, req_type, first_value, second_value, input ready);
    modport sink   (input valid, req_type, first_value, second_value, output ready);
endinterface

interface sdrm_rsp_if
    import sdrm_pkg::*;
;
    logic  valid;
    logic  ready;
    t_word quotient;
    t_word remainder;
    t_word modulo;

    modport source (output valid, quotient, remainder, modulo, input ready);
    modport sink   (input valid, quotient, remainder, modulo, output ready);
endinterface

### hdl/signed_divider_rem_mod_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_divider_rem_mod_core
// Signed 32-bit divider giving quotient, remainder and modulo.
//
// Requests come in on i_req (valid/ready); each beat may load the stored
// numerator, the stored denominator or both. Kinds 0..3 then emit one beat
// on o_rsp; kinds 4 and 5 only load; kinds 6 and 7 are dropped.
// A short microprogram runs a radix-2 restoring divider: one load step,
// 32 shift/subtract steps (one quotient bit each), a sign step, a modulo
// step and an output step. A new request is taken only once the sequencer
// is back in its idle step after the output step.
// A zero divisor or most-negative / -1 skips the divide loop, the sign step
// and the modulo step. Load-only requests leave the sequencer in idle.
// The result sits in an output register; if the receiver stalls, the
// sequencer waits in its output step until that register frees up.
// Synchronous reset sets both stored operands to 1 and empties the output.
// ----------------------------------------------------------------------------
module signed_divider_rem_mod_core
    import sdrm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdrm_req_if.sink   i_req,
    sdrm_rsp_if.source o_rsp
);

    t_step              r_pc, n_pc;
    t_ctrl              w_ctrl;
    logic               w_cond;

    t_word              r_num, r_den;
    logic [DATA_W-1:0]  r_a;      // dividend, shifts out as quotient shifts in
    logic [DATA_W-1:0]  r_dabs;
    logic [DATA_W-1:0]  r_prem;   // partial remainder
    t_cnt               r_cnt;
    logic               r_qneg, r_nneg;
    t_word              r_quo, r_rem, r_mod;

    logic               r_ov;
    t_word              r_oq, r_or, r_om;

    logic               w_accept;
    logic               w_emit_kind;
    logic               w_out_free;
    logic [DATA_W:0]    w_shift;
    logic               w_ge;
    logic               w_zero_den, w_ovf;

    assign w_ctrl   = sdrm_rom(r_pc);
    assign i_req.ready = i_rst_n && (r_pc == STEP_IDLE);
    assign w_accept = i_req.valid && i_req.ready;
    assign w_emit_kind = (i_req.req_type == KIND_NUM_EMIT)
                      || (i_req.req_type == KIND_DEN_EMIT)
                      || (i_req.req_type == KIND_BOTH_EMIT)
                      || (i_req.req_type == KIND_EMIT);
    assign w_out_free = !r_ov || o_rsp.ready;

    assign w_shift = {r_prem, r_a[DATA_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_dabs};

    assign w_zero_den = (r_den == '0);
    assign w_ovf      = (r_num == WORD_MIN) && (r_den == '1);

    always_comb begin
        unique case (w_ctrl.cond)
            COND_START:    w_cond = w_accept && w_emit_kind;
            COND_SPECIAL:  w_cond = w_zero_den || w_ovf;
            COND_CNT_MORE: w_cond = (r_cnt != CNT_LAST);
            COND_OUT_BUSY: w_cond = !w_out_free;
            default:       w_cond = 1'b0;
        endcase
        n_pc = w_cond ? w_ctrl.jt : w_ctrl.jf;
    end

    // sequencer and stored operands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= STEP_IDLE;
            r_num <= WORD_ONE;
            r_den <= WORD_ONE;
        end else begin
            r_pc <= n_pc;
            if (w_accept) begin
                unique case (i_req.req_type)
                    KIND_NUM_EMIT, KIND_NUM_SET: r_num <= i_req.first_value;
                    KIND_DEN_EMIT, KIND_DEN_SET: r_den <= i_req.first_value;
                    KIND_BOTH_EMIT: begin
                        r_num <= i_req.first_value;
                        r_den <= i_req.second_value;
                    end
                    default: ;
                endcase
            end
        end
    end

    // datapath driven by the control word
    always_ff @(posedge i_clk) begin
        unique case (w_ctrl.op)
            OP_LOAD: begin
                r_a       <= r_num[DATA_W-1] ? DATA_W'(-r_num) : DATA_W'(r_num);
                r_dabs    <= r_den[DATA_W-1] ? DATA_W'(-r_den) : DATA_W'(r_den);
                r_prem    <= '0;
                r_cnt     <= '0;
                r_qneg    <= r_num[DATA_W-1] ^ r_den[DATA_W-1];
                r_nneg    <= r_num[DATA_W-1];
                if (w_zero_den) begin
                    r_quo <= r_num[DATA_W-1] ? WORD_MIN :
                             (r_num == '0)   ? '0 : WORD_MAX;
                    r_rem <= r_num;
                    r_mod <= '0;
                end else begin
                    r_quo <= WORD_MAX;
                    r_rem <= '0;
                    r_mod <= '0;
                end
            end
            OP_STEP: begin
                r_prem <= w_ge ? DATA_W'(w_shift - {1'b0, r_dabs}) : w_shift[DATA_W-1:0];
                r_a    <= {r_a[DATA_W-2:0], w_ge};
                r_cnt  <= r_cnt + t_cnt'(1);
            end
            OP_SIGN: begin
                r_quo <= r_qneg ? t_word'(-r_a) : t_word'(r_a);
                r_rem <= r_nneg ? t_word'(-r_prem) : t_word'(r_prem);
            end
            OP_MOD: begin
                // move a nonzero remainder over to the divisor's sign
                if ((r_rem != '0) && (r_rem[DATA_W-1] != r_den[DATA_W-1])) begin
                    r_mod <= r_rem + r_den;
                end else begin
                    r_mod <= r_rem;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_ctrl.op == OP_OUT && w_out_free) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.op == OP_OUT && w_out_free) begin
            r_oq <= r_quo;
            r_or <= r_rem;
            r_om <= r_mod;
        end
    end

    assign o_rsp.valid     = r_ov;
    assign o_rsp.quotient  = r_oq;
    assign o_rsp.remainder = r_or;
    assign o_rsp.modulo    = r_om;

endmodule

### hdl/sdrm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdrm_checker
// Port-level checks on the signed divider, bound to the top level.
// ----------------------------------------------------------------------------
module sdrm_checker
    import sdrm_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_req_valid,
    input logic  i_req_ready,
    input t_kind i_req_type,
    input logic  i_rsp_valid,
    input logic  i_rsp_ready
);

    logic w_acc;
    assign w_acc = i_req_valid && i_req_ready;

    // a result beat is held until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result beat dropped while stalled");

    // an emitting request keeps the sequencer busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_req_type == KIND_NUM_EMIT || i_req_type == KIND_DEN_EMIT ||
                  i_req_type == KIND_BOTH_EMIT || i_req_type == KIND_EMIT)
        |=> !i_req_ready)
        else $error("request taken while divide in flight");

    // a new result only comes out of the output step, never from idle
    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> !$past(i_req_ready))
        else $error("result launched while idle");

    // load-only and unused kinds never produce a beat
    a_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !i_rsp_valid && !(i_req_type == KIND_NUM_EMIT ||
            i_req_type == KIND_DEN_EMIT || i_req_type == KIND_BOTH_EMIT ||
            i_req_type == KIND_EMIT)
        |=> !i_rsp_valid)
        else $error("silent request produced a result");

endmodule

bind signed_divider_rem_mod_core sdrm_checker u_sdrm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_type  (i_req.req_type),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready)
);
